>>> src/tbnt_pkg.sv
// Package for the two-blob nearest tracker.
// Holds the payload structs, the register index codes and the reset values.
// It has no dependencies.
package tbnt_pkg;

    localparam int unsigned FIELD_WIDTH     = 9;
    localparam int unsigned CFG_IDX_WIDTH   = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 8;
    localparam int unsigned RADIUS_SQ_WIDTH = 2 * CFG_DATA_WIDTH;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_MATCH_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_OVERLAP_RADIUS = 2'd1;

    // squared reset radii: 30 * 30 and 8 * 8
    localparam logic [RADIUS_SQ_WIDTH-1:0] MATCH_SQ_RESET   = 16'd900;
    localparam logic [RADIUS_SQ_WIDTH-1:0] OVERLAP_SQ_RESET = 16'd64;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] point_x;
        logic [FIELD_WIDTH-1:0] point_y;
        logic                   last_in_frame;
        logic                   empty_frame;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] beacon_x;
        logic [FIELD_WIDTH-1:0] beacon_y;
        logic [FIELD_WIDTH-1:0] car_x;
        logic [FIELD_WIDTH-1:0] car_y;
        logic                   tracking;
    } t_out_item;

endpackage

>>> src/two_blob_nearest_tracker.sv
// Two-blob nearest tracker: beacon and car tracking over streamed blob centres.
// Depends on tbnt_pkg for payload structs, register codes and reset values.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/ i_out_ready| o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// One point per cycle. Distance squares, running minimum and the end-of-frame
// update all settle in the cycle of the request; the frame result lands in a
// two-entry output queue the next cycle.
// Reset (synchronous, active low) clears tracking state and empties the queue.
// Input is held off only while both queue entries wait; cfg is always ready.
module two_blob_nearest_tracker
    import tbnt_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_in_item                  i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_out_item                 o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data
);

    localparam int unsigned PW  = COORD_WIDTH;
    localparam int unsigned PPW = 2 * PW;
    localparam int unsigned DW  = 2 * PW + 1;
    localparam int unsigned CW  = (DW > RADIUS_SQ_WIDTH) ? DW : RADIUS_SQ_WIDTH;

    function automatic logic [DW-1:0] sq_dist(input logic [PPW-1:0] a,
                                               input logic [PPW-1:0] b);
        logic [PW-1:0]  ax, ay, bx, by, dx, dy;
        logic [PPW-1:0] sx, sy;
        ax = a[PPW-1:PW];
        ay = a[PW-1:0];
        bx = b[PPW-1:PW];
        by = b[PW-1:0];
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        sx = PPW'(dx) * PPW'(dx);
        sy = PPW'(dy) * PPW'(dy);
        return DW'(sx) + DW'(sy);
    endfunction

    // config (squared radii)
    logic [RADIUS_SQ_WIDTH-1:0] r_match_sq, r_overlap_sq;

    // tracking state
    logic           r_tracking, r_prev_two;
    logic [PPW-1:0] r_beacon, r_car;
    logic [1:0]     r_seen;

    // per-frame state
    logic [PPW-1:0] r_p1, r_p2, r_bbest_p, r_cbest_p;
    logic [DW-1:0]  r_d1, r_d2, r_c1, r_c2;
    logic [CW-1:0]  r_bbest_d, r_cbest_d;
    logic           r_bfound, r_cfound;

    // output queue
    t_out_item      r_slot0, r_slot1;
    logic [1:0]     r_ocnt;

    logic           in_acc, is_point, ends_frame, push, pop;
    logic [PPW-1:0] pt;
    logic [DW-1:0]  dist_b, dist_c, dist_bc;
    logic [CW-1:0]  cur_bbest_d, cur_cbest_d, match_cw;
    logic           cur_bfound, cur_cfound, take_b, take_c, overlap;

    logic [1:0]     e_seen;
    logic [PPW-1:0] e_p1, e_p2, e_bbest_p, e_cbest_p;
    logic [DW-1:0]  e_d1, e_d2, e_c1, e_c2;
    logic [CW-1:0]  e_bbest_d, e_cbest_d;
    logic           e_bfound, e_cfound;

    logic [PPW-1:0] n_beacon, n_car;
    logic           n_tracking, n_prev_two;
    t_out_item      res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_ocnt != 2'd2);
    assign o_out_valid = (r_ocnt != 2'd0);
    assign o_out_data  = r_slot0;

    assign in_acc     = i_in_valid && o_in_ready;
    assign is_point   = !i_in_data.empty_frame;
    assign ends_frame = i_in_data.empty_frame || i_in_data.last_in_frame;
    assign push       = in_acc && ends_frame;
    assign pop        = o_out_valid && i_out_ready;

    assign pt       = {PW'(i_in_data.point_x), PW'(i_in_data.point_y)};
    assign dist_b   = sq_dist(r_beacon, pt);
    assign dist_c   = sq_dist(r_car, pt);
    assign dist_bc  = sq_dist(r_beacon, r_car);
    assign match_cw = CW'(r_match_sq);
    assign overlap  = CW'(dist_bc) < CW'(r_overlap_sq);

    // first point of a frame reloads the running minimum from the current radius
    assign cur_bbest_d = (r_seen == 2'd0) ? match_cw : r_bbest_d;
    assign cur_cbest_d = (r_seen == 2'd0) ? match_cw : r_cbest_d;
    assign cur_bfound  = (r_seen != 2'd0) && r_bfound;
    assign cur_cfound  = (r_seen != 2'd0) && r_cfound;
    assign take_b      = is_point && (CW'(dist_b) < cur_bbest_d);
    assign take_c      = is_point && (CW'(dist_c) < cur_cbest_d);

    // frame state including the current request
    always_comb begin
        e_seen    = r_seen;
        e_p1      = r_p1;
        e_p2      = r_p2;
        e_d1      = r_d1;
        e_d2      = r_d2;
        e_c1      = r_c1;
        e_c2      = r_c2;
        e_bbest_d = take_b ? CW'(dist_b) : cur_bbest_d;
        e_cbest_d = take_c ? CW'(dist_c) : cur_cbest_d;
        e_bbest_p = take_b ? pt : r_bbest_p;
        e_cbest_p = take_c ? pt : r_cbest_p;
        e_bfound  = cur_bfound || take_b;
        e_cfound  = cur_cfound || take_c;
        if (is_point) begin
            if (r_seen == 2'd0) begin
                e_p1 = pt;
                e_d1 = dist_b;
                e_c1 = dist_c;
            end else if (r_seen == 2'd1) begin
                e_p2 = pt;
                e_d2 = dist_b;
                e_c2 = dist_c;
            end
            if (r_seen != 2'd3) begin
                e_seen = r_seen + 2'd1;
            end
        end
    end

    // end-of-frame update
    always_comb begin
        n_beacon   = r_beacon;
        n_car      = r_car;
        n_tracking = r_tracking;
        n_prev_two = r_prev_two;
        if (ends_frame) begin
            if (!r_tracking) begin
                if (e_seen == 2'd1) begin
                    n_beacon   = e_p1;
                    n_tracking = 1'b1;
                    n_prev_two = 1'b0;
                end
            end else begin
                if (e_seen == 2'd1) begin
                    if (!overlap) begin
                        n_beacon = e_p1;
                    end
                end else if (!r_prev_two && e_seen == 2'd2) begin
                    if (!overlap) begin
                        if (e_d1 > e_d2) begin
                            if (CW'(e_d2) < match_cw) begin
                                n_beacon = e_p2;
                                n_car    = e_p1;
                            end
                        end else if (CW'(e_d1) < match_cw) begin
                            n_beacon = e_p1;
                            n_car    = e_p2;
                        end
                    end else if (e_c1 > e_c2) begin
                        n_car    = e_p2;
                        n_beacon = e_p1;
                    end else begin
                        n_beacon = e_p2;
                        n_car    = e_p1;
                    end
                end else if (!r_prev_two && e_seen == 2'd3) begin
                    if (!overlap && e_bfound) begin
                        n_beacon = e_bbest_p;
                    end
                end else if (r_prev_two && e_seen != 2'd0) begin
                    if (e_bfound) begin
                        n_beacon = e_bbest_p;
                    end
                    if (e_cfound) begin
                        n_car = e_cbest_p;
                    end
                end
                n_prev_two = (e_seen >= 2'd2);
            end
        end
    end

    always_comb begin
        res.beacon_x = FIELD_WIDTH'(n_beacon[PPW-1:PW]);
        res.beacon_y = FIELD_WIDTH'(n_beacon[PW-1:0]);
        res.car_x    = FIELD_WIDTH'(n_car[PPW-1:PW]);
        res.car_y    = FIELD_WIDTH'(n_car[PW-1:0]);
        res.tracking = n_tracking;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_sq   <= MATCH_SQ_RESET;
            r_overlap_sq <= OVERLAP_SQ_RESET;
            r_tracking   <= 1'b0;
            r_prev_two   <= 1'b0;
            r_beacon     <= '0;
            r_car        <= '0;
            r_seen       <= 2'd0;
            r_bfound     <= 1'b0;
            r_cfound     <= 1'b0;
            r_ocnt       <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_MATCH_RADIUS) begin
                    r_match_sq <= RADIUS_SQ_WIDTH'(i_cfg_data) *
                                  RADIUS_SQ_WIDTH'(i_cfg_data);
                end else if (i_cfg_index == REG_OVERLAP_RADIUS) begin
                    r_overlap_sq <= RADIUS_SQ_WIDTH'(i_cfg_data) *
                                    RADIUS_SQ_WIDTH'(i_cfg_data);
                end
            end
            if (in_acc) begin
                r_tracking <= n_tracking;
                r_prev_two <= n_prev_two;
                r_beacon   <= n_beacon;
                r_car      <= n_car;
                r_seen     <= ends_frame ? 2'd0 : e_seen;
                r_bfound   <= e_bfound;
                r_cfound   <= e_cfound;
            end
            r_ocnt <= r_ocnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // frame payload and output queue entries
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1      <= e_p1;
            r_p2      <= e_p2;
            r_d1      <= e_d1;
            r_d2      <= e_d2;
            r_c1      <= e_c1;
            r_c2      <= e_c2;
            r_bbest_d <= e_bbest_d;
            r_cbest_d <= e_cbest_d;
            r_bbest_p <= e_bbest_p;
            r_cbest_p <= e_cbest_p;
        end
        if (pop) begin
            r_slot0 <= r_slot1;
            if (push && r_ocnt == 2'd1) begin
                r_slot0 <= res;
            end
            if (push && r_ocnt == 2'd2) begin
                r_slot1 <= res;
            end
        end else if (push) begin
            if (r_ocnt == 2'd0) begin
                r_slot0 <= res;
            end else begin
                r_slot1 <= res;
            end
        end
    end

`ifndef SYNTHESIS
    a_ocnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("output queue count out of range");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_out_valid)
        else $error("frame end did not present a result");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_seen == 2'd0))
        else $error("point count not cleared at frame end");

    a_tracking_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tracking |=> r_tracking)
        else $error("tracking dropped");

    a_prev_two_needs_tracking: assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        r_prev_two |-> r_tracking)
        else $error("two-blob history without tracking");
`endif

endmodule
